// ===== rtl/cell_page_record_allocator_macros.svh =====
// Assertion macros for the cell page record allocator.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef CELL_PAGE_RECORD_ALLOCATOR_MACROS_SVH
`define CELL_PAGE_RECORD_ALLOCATOR_MACROS_SVH

// Plain property check, disabled while in reset.
`define CPRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication check, disabled while in reset.
`define CPRA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpra_pkg.sv =====
// Shared types and codes for the cell page record allocator.
// No dependencies; imported by the top level.
package cpra_pkg;

    localparam int PAGE_SLOTS = 3;
    localparam int FAIL_W     = 16;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPAGES = 2'd1;
    localparam logic [1:0] ST_BADIDX  = 2'd2;
    localparam logic [1:0] ST_NOSTORE = 2'd3;

    // configuration register indexes
    localparam logic REG_CELL_COUNT  = 1'b0;
    localparam logic REG_PAGE_BUDGET = 1'b1;

    // write and read modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_PUSH,
        S_CLAIM,
        S_POPW,
        S_UNDO,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

// ===== rtl/cell_page_record_allocator.sv =====
// Cell page record allocator: one record per cell (channel count plus up to three
// page numbers), a LIFO free-page stack in RAM and a bump counter for fresh pages.
// Depends on cpra_pkg, cpra_ram and cell_page_record_allocator_macros.svh.
//
// Usage notes. After reset the record RAM is swept to its reset value (one channel,
// no pages), one cell per cycle, and in_ready stays low until all CELLS records
// are swept; configuration words are taken during the sweep and at any time.
// One input word is handled at a time by a small sequencer around the shared
// free-stack pointer and its stack accesses. A read or a rejected word moves from
// acceptance to a record lookup and then to the output register. A write pushes
// the old pages onto the stack (one per cycle), then claims the demanded pages,
// each by a stack pop with a wait state for the registered RAM read or as a
// fresh page. If it runs out of pages it pushes the claimed pages back; then it
// writes the record. A finished word sits in an output register, so the next
// input word is accepted while it waits to be taken.
// Page numbers popped from the stack are not rechecked against the page budget.
`include "cell_page_record_allocator_macros.svh"

module cell_page_record_allocator
    import cpra_pkg::*;
#(
    parameter int CELLS             = 4096,
    parameter int PAGE_LIMIT        = 16384,
    parameter int CHANNELS_PER_PAGE = 3,
    parameter int MAX_CHANNELS      = 8,
    localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int CNT_W  = $clog2(CELLS + 1),
    localparam int PG_W   = $clog2(PAGE_LIMIT),
    localparam int DEP_W  = $clog2(PAGE_LIMIT + 1),
    localparam int CHAN_W = $clog2(MAX_CHANNELS + 1),
    localparam int CFG_W  = (CNT_W > DEP_W) ? CNT_W : DEP_W
) (
    input  logic              clk,
    input  logic              rst_n,

    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    // input words
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [IDX_W-1:0]  cell_index,
    input  logic [7:0]        channel_request,

    // result words
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [CHAN_W-1:0] channels_held,
    output logic [1:0]        pages_held,
    output logic [PG_W-1:0]   first_page,
    output logic [PG_W-1:0]   second_page,
    output logic [PG_W-1:0]   third_page,
    output logic [FAIL_W-1:0] failed_cells
);

    // Record layout in RAM: {channels-1, page count, slot2, slot1, slot0}.
    // All-zero therefore is the reset record: one channel, no pages.
    localparam int CM1_W = $clog2(MAX_CHANNELS);
    localparam int REC_W = CM1_W + 2 + PAGE_SLOTS * PG_W;
    localparam int WNT_W = CHAN_W + 2;

    localparam logic [CHAN_W-1:0] CHAN_ONE = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(MAX_CHANNELS);
    // channel counts at which the first, second and third page become needed
    localparam logic [WNT_W-1:0]  WANT_1   = WNT_W'(2);
    localparam logic [WNT_W-1:0]  WANT_2   = WNT_W'(CHANNELS_PER_PAGE + 2);
    localparam logic [WNT_W-1:0]  WANT_3   = WNT_W'(2 * CHANNELS_PER_PAGE + 2);
    localparam logic [DEP_W-1:0]  DEP_ONE  = DEP_W'(1);
    localparam logic [DEP_W-1:0]  DEP_LIM  = DEP_W'(PAGE_LIMIT);
    localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

    typedef logic [PAGE_SLOTS-1:0][PG_W-1:0] pages_t;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]   cell_count_reg;
    logic [DEP_W-1:0]   page_budget_reg;
    logic [DEP_W-1:0]   free_depth_reg, free_depth_next;
    logic [DEP_W-1:0]   fresh_reg, fresh_next;
    logic [FAIL_W-1:0]  failed_reg, failed_next;
    logic [1:0]         k_reg, k_next;
    logic               out_valid_reg, out_valid_next;

    // ---------------------------------------------------------------
    // Payload registers for the word in flight and the result word
    // ---------------------------------------------------------------
    logic               mode_reg, mode_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CHAN_W-1:0]  req_reg, req_next;
    logic [1:0]         want_reg, want_next;
    logic [1:0]         old_np_reg, old_np_next;
    pages_t             old_pg_reg, old_pg_next;
    logic [CHAN_W-1:0]  new_ch_reg, new_ch_next;
    logic [1:0]         new_np_reg, new_np_next;
    pages_t             new_pg_reg, new_pg_next;
    logic [1:0]         res_status_reg, res_status_next;

    logic [1:0]         out_status_reg, out_status_next;
    logic [CHAN_W-1:0]  out_ch_reg, out_ch_next;
    logic [1:0]         out_np_reg, out_np_next;
    pages_t             out_pg_reg, out_pg_next;
    logic [FAIL_W-1:0]  out_failed_reg, out_failed_next;

    // ---------------------------------------------------------------
    // RAM ports
    // ---------------------------------------------------------------
    logic               rec_we, rec_re;
    logic [IDX_W-1:0]   rec_waddr, rec_raddr;
    logic [REC_W-1:0]   rec_wdata, rec_rdata;

    logic               stk_we, stk_re;
    logic [PG_W-1:0]    stk_waddr, stk_raddr;
    logic [PG_W-1:0]    stk_wdata, stk_rdata;

    cpra_ram #(
        .WIDTH (REC_W),
        .DEPTH (CELLS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    cpra_ram #(
        .WIDTH (PG_W),
        .DEPTH (PAGE_LIMIT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // ---------------------------------------------------------------
    // Request clamp and page demand, taken at acceptance
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0]  req_clamp;
    logic [WNT_W-1:0]   req_wide;
    logic [1:0]         want_calc;

    always_comb
    begin
        if (channel_request == 8'd0)
        begin
            req_clamp = CHAN_ONE;
        end
        else if (channel_request > 8'(MAX_CHANNELS))
        begin
            req_clamp = CHAN_MAX;
        end
        else
        begin
            req_clamp = CHAN_W'(channel_request);
        end
        // ceil((req - 1) / CHANNELS_PER_PAGE) as a count of thresholds passed,
        // which also caps it at three slots
        req_wide  = WNT_W'(req_clamp);
        want_calc = 2'(req_wide >= WANT_1) + 2'(req_wide >= WANT_2) +
                    2'(req_wide >= WANT_3);
    end

    // ---------------------------------------------------------------
    // Decoded record from the RAM, and rejection test
    // ---------------------------------------------------------------
    logic [CHAN_W-1:0]  rd_ch;
    logic [1:0]         rd_np;
    pages_t             rd_pg;
    logic               bad_idx;

    assign rd_ch   = CHAN_W'(rec_rdata[REC_W-1 -: CM1_W]) + CHAN_ONE;
    assign rd_np   = rec_rdata[PAGE_SLOTS*PG_W +: 2];
    assign rd_pg   = rec_rdata[PAGE_SLOTS*PG_W-1:0];
    assign bad_idx = (CNT_W'(idx_reg) >= cell_count_reg) ||
                     (CNT_W'(idx_reg) >= CNT_W'(CELLS));

    // Shared stack pointer tests, fresh page limit and output slot test
    logic               stk_has_room;
    logic               stk_empty;
    logic               fresh_ok;
    logic               out_free;

    assign stk_has_room = free_depth_reg < DEP_LIM;
    assign stk_empty    = free_depth_reg == '0;
    assign fresh_ok     = (fresh_reg < page_budget_reg) && (fresh_reg < DEP_LIM);
    assign out_free     = !out_valid_reg || out_ready;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == IDX_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (bad_idx || mode_reg == MODE_READ || page_budget_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (k_reg >= old_np_reg)
                begin
                    state_next = S_CLAIM;
                end
            end
            S_CLAIM:
            begin
                if (k_reg == want_reg)
                begin
                    state_next = S_WRITE;
                end
                else if (!stk_empty)
                begin
                    state_next = S_POPW;
                end
                else if (!fresh_ok)
                begin
                    state_next = S_UNDO;
                end
            end
            S_POPW:
            begin
                state_next = S_CLAIM;
            end
            S_UNDO:
            begin
                if (k_reg >= new_np_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and RAM controls
    // ---------------------------------------------------------------
    always_comb
    begin
        clr_next        = clr_reg;
        free_depth_next = free_depth_reg;
        fresh_next      = fresh_reg;
        failed_next     = failed_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        mode_next       = mode_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        want_next       = want_reg;
        old_np_next     = old_np_reg;
        old_pg_next     = old_pg_reg;
        new_ch_next     = new_ch_reg;
        new_np_next     = new_np_reg;
        new_pg_next     = new_pg_reg;
        res_status_next = res_status_reg;

        out_status_next = out_status_reg;
        out_ch_next     = out_ch_reg;
        out_np_next     = out_np_reg;
        out_pg_next     = out_pg_reg;
        out_failed_next = out_failed_reg;

        rec_we    = 1'b0;
        rec_waddr = idx_reg;
        rec_wdata = {CM1_W'(new_ch_reg - CHAN_ONE), new_np_reg, new_pg_reg};
        rec_re    = 1'b0;
        rec_raddr = cell_index;

        stk_we    = 1'b0;
        stk_waddr = free_depth_reg[PG_W-1:0];
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = PG_W'(free_depth_reg - DEP_ONE);

        case (state_reg)
            S_CLEAR:
            begin
                rec_we    = 1'b1;
                rec_waddr = clr_reg;
                rec_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rec_re    = 1'b1;
                    mode_next = mode;
                    idx_next  = cell_index;
                    req_next  = req_clamp;
                    want_next = want_calc;
                end
            end
            S_LOOK:
            begin
                old_np_next     = rd_np;
                old_pg_next     = rd_pg;
                new_ch_next     = rd_ch;
                new_np_next     = rd_np;
                new_pg_next     = rd_pg;
                k_next          = 2'd0;
                res_status_next = ST_OK;
                if (bad_idx)
                begin
                    new_ch_next     = CHAN_ONE;
                    new_np_next     = 2'd0;
                    new_pg_next     = '0;
                    res_status_next = ST_BADIDX;
                end
                else if (mode_reg == MODE_READ)
                begin
                    res_status_next = ST_OK;
                end
                else if (page_budget_reg == '0)
                begin
                    res_status_next = ST_NOSTORE;
                end
            end
            S_PUSH:
            begin
                if (k_reg < old_np_reg)
                begin
                    // return an old page; a full stack drops it
                    if (stk_has_room)
                    begin
                        stk_we          = 1'b1;
                        stk_wdata       = old_pg_reg[k_reg];
                        free_depth_next = free_depth_reg + DEP_ONE;
                    end
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    k_next      = 2'd0;
                    new_ch_next = req_reg;
                    new_np_next = 2'd0;
                    new_pg_next = '0;
                end
            end
            S_CLAIM:
            begin
                if (k_reg == want_reg)
                begin
                    res_status_next = ST_OK;
                end
                else if (!stk_empty)
                begin
                    stk_re          = 1'b1;
                    free_depth_next = free_depth_reg - DEP_ONE;
                end
                else if (fresh_ok)
                begin
                    new_pg_next[k_reg] = fresh_reg[PG_W-1:0];
                    new_np_next        = k_reg + 2'd1;
                    fresh_next         = fresh_reg + DEP_ONE;
                    k_next             = k_reg + 2'd1;
                end
                else
                begin
                    // out of pages: undo the claims of this word
                    res_status_next = ST_NOPAGES;
                    k_next          = 2'd0;
                    if (failed_reg != FAIL_MAX)
                    begin
                        failed_next = failed_reg + FAIL_W'(1);
                    end
                end
            end
            S_POPW:
            begin
                new_pg_next[k_reg] = stk_rdata;
                new_np_next        = k_reg + 2'd1;
                k_next             = k_reg + 2'd1;
            end
            S_UNDO:
            begin
                if (k_reg < new_np_reg)
                begin
                    if (stk_has_room)
                    begin
                        stk_we          = 1'b1;
                        stk_wdata       = new_pg_reg[k_reg];
                        free_depth_next = free_depth_reg + DEP_ONE;
                    end
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    new_ch_next = CHAN_ONE;
                    new_np_next = 2'd0;
                    new_pg_next = '0;
                end
            end
            S_WRITE:
            begin
                rec_we = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_ch_next     = new_ch_reg;
                    out_np_next     = new_np_reg;
                    out_failed_next = failed_reg;
                    for (int s = 0; s < PAGE_SLOTS; s++)
                    begin
                        out_pg_next[s] = (2'(s) < new_np_reg) ? new_pg_reg[s] : '0;
                    end
                end
            end
            default:
            begin
                k_next = 2'd0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            cell_count_reg  <= CNT_W'(CELLS);
            page_budget_reg <= DEP_LIM;
            free_depth_reg  <= '0;
            fresh_reg       <= '0;
            failed_reg      <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_depth_reg <= free_depth_next;
            fresh_reg      <= fresh_next;
            failed_reg     <= failed_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CELL_COUNT:  cell_count_reg  <= cfg_data[CNT_W-1:0];
                    REG_PAGE_BUDGET: page_budget_reg <= cfg_data[DEP_W-1:0];
                    default:         cell_count_reg  <= cell_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        req_reg        <= req_next;
        want_reg       <= want_next;
        old_np_reg     <= old_np_next;
        old_pg_reg     <= old_pg_next;
        new_ch_reg     <= new_ch_next;
        new_np_reg     <= new_np_next;
        new_pg_reg     <= new_pg_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_ch_reg     <= out_ch_next;
        out_np_reg     <= out_np_next;
        out_pg_reg     <= out_pg_next;
        out_failed_reg <= out_failed_next;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign channels_held = out_ch_reg;
    assign pages_held    = out_np_reg;
    assign first_page    = out_pg_reg[0];
    assign second_page   = out_pg_reg[1];
    assign third_page    = out_pg_reg[2];
    assign failed_cells  = out_failed_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `CPRA_ASSERT_IMPL(a_claim_complete,
        state_reg == S_WRITE && res_status_reg == ST_OK,
        new_np_reg == want_reg && new_ch_reg == req_reg,
        "successful write stores fewer pages than demanded")

    `CPRA_ASSERT_IMPL(a_fail_degrades,
        state_reg == S_WRITE && res_status_reg == ST_NOPAGES,
        new_ch_reg == CHAN_ONE && new_np_reg == 2'd0,
        "failed write does not leave a single-channel empty record")

    `CPRA_ASSERT_IMPL(a_fresh_in_range,
        fresh_reg != $past(fresh_reg),
        $past(fresh_reg) < $past(page_budget_reg) && $past(fresh_reg) < DEP_LIM,
        "fresh page handed out past capacity")

    `CPRA_ASSERT(a_depth_step,
        (free_depth_reg == $past(free_depth_reg)) ||
        (free_depth_reg == $past(free_depth_reg) + DEP_ONE) ||
        (free_depth_reg + DEP_ONE == $past(free_depth_reg)),
        "free stack depth moved by more than one entry")

endmodule

// ===== rtl/cpra_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
